// ===== design/fbfl_pkg.sv =====
// fbfl_pkg: shared types and constants for the fixed block free list allocator
// holds opcode, status and register index codes plus the config register struct
// no dependencies
`default_nettype none

package fbfl_pkg;

    localparam int POOL_BLOCKS_DEF = 1024;

    // fixed field widths
    localparam int OPCODE_W    = 2;
    localparam int IDX_IN_W    = 10;
    localparam int STATUS_W    = 2;
    localparam int ADDR_W      = 40;
    localparam int BASE_W      = 32;
    localparam int BSIZE_W     = 17;
    localparam int COUNT_W     = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

    // config reset values
    localparam logic [BASE_W-1:0]  POOL_BASE_RST   = 32'd0;
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST  = 17'd8;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    typedef struct packed {
        logic [BASE_W-1:0]  pool_base;
        logic [BSIZE_W-1:0] block_size_bytes;
        logic [COUNT_W-1:0] block_count;
    } cfg_t;

endpackage

`default_nettype wire

// ===== design/fbfl_ram.sv =====
// fbfl_ram: generic single write port, single read port ram with registered read
// contents undefined until written
// no dependencies
`default_nettype none

module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/fbfl_cfg_regs.sv =====
// fbfl_cfg_regs: configuration registers of the allocator (base, block size, count)
// depends on fbfl_pkg
`default_nettype none

module fbfl_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fbfl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output fbfl_pkg::cfg_t                        cfg
);

    fbfl_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pool_base        <= fbfl_pkg::POOL_BASE_RST;
            cfg_reg.block_size_bytes <= fbfl_pkg::BLOCK_SIZE_RST;
            cfg_reg.block_count      <= fbfl_pkg::BLOCK_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                fbfl_pkg::REG_POOL_BASE: begin
                    cfg_reg.pool_base <= cfg_wdata;
                end
                fbfl_pkg::REG_BLOCK_SIZE: begin
                    cfg_reg.block_size_bytes <= cfg_wdata[fbfl_pkg::BSIZE_W-1:0];
                end
                fbfl_pkg::REG_BLOCK_COUNT: begin
                    cfg_reg.block_count <= cfg_wdata[fbfl_pkg::COUNT_W-1:0];
                end
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/fbfl_ctrl.sv =====
// fbfl_ctrl: free list control, head and fresh counter, address multiply, result register
// drives the link ram (read head link, write on free); depends on fbfl_pkg
`default_nettype none

module fbfl_ctrl #(
    parameter int POOL_BLOCKS = fbfl_pkg::POOL_BLOCKS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire fbfl_pkg::cfg_t                          cfg,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [fbfl_pkg::OPCODE_W-1:0]           s_opcode,
    input  wire logic [fbfl_pkg::IDX_IN_W-1:0]           s_block_index,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic      [fbfl_pkg::STATUS_W-1:0]           m_status,
    output logic      [fbfl_pkg::IDX_IN_W-1:0]           m_granted_index,
    output logic      [fbfl_pkg::ADDR_W-1:0]             m_granted_address,
    output logic                                         m_any_free,
    output logic                                         ram_we,
    output logic      [$clog2(POOL_BLOCKS)-1:0]          ram_waddr,
    output logic      [$clog2(POOL_BLOCKS+1)-1:0]        ram_wdata,
    output logic      [$clog2(POOL_BLOCKS)-1:0]          ram_raddr,
    input  wire logic [$clog2(POOL_BLOCKS+1)-1:0]        ram_rdata
);

    localparam int IDX_W  = $clog2(POOL_BLOCKS);
    localparam int LINK_W = $clog2(POOL_BLOCKS + 1);
    localparam int CNT_W  = (LINK_W > fbfl_pkg::COUNT_W) ? LINK_W : fbfl_pkg::COUNT_W;
    localparam int PROD_W = IDX_W + fbfl_pkg::BSIZE_W;

    localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_BLOCKS);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_BLOCKS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                            state_reg, state_next;
    logic [LINK_W-1:0]               free_head_reg, free_head_next;
    logic [LINK_W-1:0]               fresh_next_reg, fresh_next_next;
    logic [fbfl_pkg::OPCODE_W-1:0]   op_reg;
    logic [fbfl_pkg::IDX_IN_W-1:0]   idx_reg;
    logic [PROD_W-1:0]               prod_reg;

    logic                            m_valid_reg;
    logic [fbfl_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [fbfl_pkg::IDX_IN_W-1:0]   gidx_reg, gidx_next;
    logic [fbfl_pkg::ADDR_W-1:0]     gaddr_reg, gaddr_next;
    logic                            any_free_reg, any_free_next;

    logic                            accept;
    logic                            commit;
    logic [CNT_W-1:0]                eff_count;
    logic                            head_valid;
    logic                            fresh_ok;
    logic                            free_ok;
    logic                            granted;
    logic [IDX_W-1:0]                alloc_idx;
    logic [CNT_W-1:0]                alloc_idx_ext;
    logic [CNT_W-1:0]                idx_in_ext;
    logic [LINK_W-1:0]               free_link;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    // a finished item only retires when the output register can take it
    assign commit  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    assign eff_count  = (CNT_W'(cfg.block_count) > POOL_CNT) ? POOL_CNT
                                                              : CNT_W'(cfg.block_count);
    assign head_valid = (free_head_reg < NULL_LINK);
    assign fresh_ok   = (CNT_W'(fresh_next_reg) < eff_count);
    assign idx_in_ext = CNT_W'(idx_reg);
    assign free_ok    = (idx_in_ext < eff_count);
    assign free_link  = idx_in_ext[LINK_W-1:0];

    // head and fresh counter do not move between accept and retire
    assign alloc_idx     = head_valid ? free_head_reg[IDX_W-1:0] : fresh_next_reg[IDX_W-1:0];
    assign alloc_idx_ext = CNT_W'(alloc_idx);

    // link of the current head is read every cycle, valid in the next cycle
    assign ram_raddr = free_head_reg[IDX_W-1:0];
    assign ram_waddr = idx_in_ext[IDX_W-1:0];
    assign ram_wdata = free_head_reg;

    always_comb begin
        free_head_next  = free_head_reg;
        fresh_next_next = fresh_next_reg;
        status_next     = fbfl_pkg::ST_OK;
        granted         = 1'b0;
        ram_we          = 1'b0;
        unique case (op_reg)
            fbfl_pkg::OP_ALLOC: begin
                if (head_valid) begin
                    free_head_next = ram_rdata;
                    granted        = 1'b1;
                end else if (fresh_ok) begin
                    fresh_next_next = LINK_W'(fresh_next_reg + 1'b1);
                    granted         = 1'b1;
                end else begin
                    status_next = fbfl_pkg::ST_EMPTY;
                end
            end
            fbfl_pkg::OP_FREE: begin
                if (free_ok) begin
                    ram_we         = commit;
                    free_head_next = free_link;
                end else begin
                    status_next = fbfl_pkg::ST_RANGE;
                end
            end
            fbfl_pkg::OP_CLEAR: begin
                free_head_next  = NULL_LINK;
                fresh_next_next = '0;
            end
            default: begin
                // no operation
            end
        endcase

        gidx_next     = granted ? alloc_idx_ext[fbfl_pkg::IDX_IN_W-1:0] : '0;
        gaddr_next    = granted ? (fbfl_pkg::ADDR_W'(cfg.pool_base)
                                   + fbfl_pkg::ADDR_W'(prod_reg)) : '0;
        any_free_next = (free_head_next < NULL_LINK)
                     || (CNT_W'(fresh_next_next) < eff_count);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            free_head_reg  <= NULL_LINK;
            fresh_next_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                free_head_reg  <= free_head_next;
                fresh_next_reg <= fresh_next_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and the index times size product
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_opcode;
            idx_reg  <= s_block_index;
            prod_reg <= PROD_W'(alloc_idx * cfg.block_size_bytes);
        end
        if (commit) begin
            status_reg   <= status_next;
            gidx_reg     <= gidx_next;
            gaddr_reg    <= gaddr_next;
            any_free_reg <= any_free_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_granted_index   = gidx_reg;
    assign m_granted_address = gaddr_reg;
    assign m_any_free        = any_free_reg;

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg <= NULL_LINK)
        else $error("free list head beyond null marker");

    a_fresh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_next_reg <= NULL_LINK)
        else $error("fresh block counter beyond pool size");

    a_retire_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid_reg)
        else $error("retired item not presented on result channel");

    a_free_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && op_reg == fbfl_pkg::OP_FREE && free_ok)
        |=> free_head_reg == $past(free_link))
        else $error("freed block did not become list head");

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && !commit) |=> (state_reg == ST_EXEC) && !s_ready)
        else $error("item dropped while waiting for result slot");

endmodule

`default_nettype wire

// ===== design/fixed_block_free_list_allocator_unit.sv =====
// fixed_block_free_list_allocator_unit: top level of the pool allocator
// instantiates fbfl_cfg_regs, fbfl_ctrl and fbfl_ram; depends on fbfl_pkg
//
//   channel   ports                                   direction
//   s_        opcode, block_index                     in
//   m_        status, granted_index/address, any_free out
//   cfg_      index, wdata                            in
//
// per item: accept, then retire once the link read of the head is back
// the registered read port of the link ram is what retire waits for
// a result waits in the output register while the next item is accepted
// a second item stalls in its retire cycle until the waiting result is taken
// reset empties the list lazily: head to null, fresh counter to zero, no ram sweep
`default_nettype none

module fixed_block_free_list_allocator_unit #(
    parameter int POOL_BLOCKS = fbfl_pkg::POOL_BLOCKS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [fbfl_pkg::OPCODE_W-1:0]    s_opcode,
    input  wire logic [fbfl_pkg::IDX_IN_W-1:0]    s_block_index,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [fbfl_pkg::STATUS_W-1:0]    m_status,
    output logic      [fbfl_pkg::IDX_IN_W-1:0]    m_granted_index,
    output logic      [fbfl_pkg::ADDR_W-1:0]      m_granted_address,
    output logic                                  m_any_free,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fbfl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IDX_W  = $clog2(POOL_BLOCKS);
    localparam int LINK_W = $clog2(POOL_BLOCKS + 1);

    fbfl_pkg::cfg_t       cfg;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [LINK_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [LINK_W-1:0]    ram_rdata;

    fbfl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fbfl_ctrl #(
        .POOL_BLOCKS (POOL_BLOCKS)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_block_index     (s_block_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_index   (m_granted_index),
        .m_granted_address (m_granted_address),
        .m_any_free        (m_any_free),
        .ram_we            (ram_we),
        .ram_waddr         (ram_waddr),
        .ram_wdata         (ram_wdata),
        .ram_raddr         (ram_raddr),
        .ram_rdata         (ram_rdata)
    );

    // next_link store, one entry per block
    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_BLOCKS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for fixed_block_free_list_allocator_unit: pool allocate, free and clear
// a directed table, partly with fixed expected replies, then random segments checked against an in-bench pool model
// depends on fbfl_pkg and the design sources
module testbench;

    localparam int OPCODE_W        = fbfl_pkg::OPCODE_W;
    localparam int IDX_IN_W        = fbfl_pkg::IDX_IN_W;
    localparam int STATUS_W        = fbfl_pkg::STATUS_W;
    localparam int ADDR_W          = fbfl_pkg::ADDR_W;
    localparam int BASE_W          = fbfl_pkg::BASE_W;
    localparam int BSIZE_W         = fbfl_pkg::BSIZE_W;
    localparam int COUNT_W         = fbfl_pkg::COUNT_W;
    localparam int CFG_IDX_W       = fbfl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = fbfl_pkg::CFG_DATA_W;
    localparam int POOL_BLOCKS_DEF = fbfl_pkg::POOL_BLOCKS_DEF;

    localparam logic [OPCODE_W-1:0]  OP_ALLOC        = fbfl_pkg::OP_ALLOC;
    localparam logic [OPCODE_W-1:0]  OP_FREE         = fbfl_pkg::OP_FREE;
    localparam logic [OPCODE_W-1:0]  OP_CLEAR        = fbfl_pkg::OP_CLEAR;
    localparam logic [STATUS_W-1:0]  ST_OK           = fbfl_pkg::ST_OK;
    localparam logic [STATUS_W-1:0]  ST_EMPTY        = fbfl_pkg::ST_EMPTY;
    localparam logic [STATUS_W-1:0]  ST_RANGE        = fbfl_pkg::ST_RANGE;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = fbfl_pkg::REG_POOL_BASE;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = fbfl_pkg::REG_BLOCK_SIZE;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = fbfl_pkg::REG_BLOCK_COUNT;
    localparam logic [BASE_W-1:0]    POOL_BASE_RST   = fbfl_pkg::POOL_BASE_RST;
    localparam logic [BSIZE_W-1:0]   BLOCK_SIZE_RST  = fbfl_pkg::BLOCK_SIZE_RST;
    localparam logic [COUNT_W-1:0]   BLOCK_COUNT_RST = fbfl_pkg::BLOCK_COUNT_RST;

    localparam int              DIR_ROWS    = 28;
    localparam int              SEGMENTS    = 15;
    localparam int              SEG_ITEMS   = 70;
    localparam int              CYCLE_LIMIT = 200000;
    localparam logic [10:0]     POOL_SIZE   = 11'(POOL_BLOCKS_DEF);
    localparam logic [10:0]     NULL_LINK   = POOL_SIZE;
    localparam logic [OPCODE_W-1:0]  OP_NOP     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_IN_W-1:0] granted_index;
        logic [ADDR_W-1:0]   granted_address;
        logic                any_free;
    } reply_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [1:0]          code;
        logic [31:0]         data;
        logic                typed;
        logic [STATUS_W-1:0] e_status;
        logic [IDX_IN_W-1:0] e_index;
        logic [ADDR_W-1:0]   e_address;
        logic                e_free;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [OPCODE_W-1:0]    s_opcode = '0;
    logic [IDX_IN_W-1:0]    s_block_index = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STATUS_W-1:0]    m_status;
    logic [IDX_IN_W-1:0]    m_granted_index;
    logic [ADDR_W-1:0]      m_granted_address;
    logic                   m_any_free;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // pool mirror and register mirror
    logic [10:0]            link_mem [POOL_BLOCKS_DEF];
    logic [10:0]            head_blk = NULL_LINK;
    logic [10:0]            fresh_blk = '0;
    logic [BASE_W-1:0]      base_reg = POOL_BASE_RST;
    logic [BSIZE_W-1:0]     size_reg = BLOCK_SIZE_RST;
    logic [COUNT_W-1:0]     count_reg = BLOCK_COUNT_RST;

    reply_t                 pending_replies [$];
    reply_t                 oldest_reply;
    int                     held_blocks [$];
    stim_row_t              stim_table [DIR_ROWS];
    int                     mismatches = 0;
    int                     cycle_count = 0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;

    fixed_block_free_list_allocator_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_block_index     (s_block_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_index   (m_granted_index),
        .m_granted_address (m_granted_address),
        .m_any_free        (m_any_free),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("CHECKS FAILED");
        $finish;
    end

    // applies one item to the pool mirror and returns the reply it produces
    function automatic reply_t pool_apply(input logic [OPCODE_W-1:0] op,
                                          input logic [IDX_IN_W-1:0] idx);
        reply_t      r;
        logic [10:0] limit;
        logic [10:0] blk;
        logic [63:0] prod;
        logic        got;
        r = '0;
        limit = (count_reg > POOL_SIZE) ? POOL_SIZE : count_reg;
        got = 1'b0;
        blk = '0;
        case (op)
            OP_ALLOC: begin
                if (head_blk < POOL_SIZE) begin
                    blk = head_blk;
                    head_blk = link_mem[head_blk[9:0]];
                    got = 1'b1;
                end else if (fresh_blk < limit) begin
                    blk = fresh_blk;
                    fresh_blk = fresh_blk + 11'd1;
                    got = 1'b1;
                end
                if (got) begin
                    prod = {32'd0, base_reg} + {53'd0, blk} * {47'd0, size_reg};
                    r.granted_index = blk[9:0];
                    r.granted_address = prod[ADDR_W-1:0];
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            OP_FREE: begin
                if ({1'b0, idx} < limit) begin
                    link_mem[idx] = head_blk;
                    head_blk = {1'b0, idx};
                end else begin
                    r.status = ST_RANGE;
                end
            end
            OP_CLEAR: begin
                head_blk = NULL_LINK;
                fresh_blk = '0;
            end
            default: ;
        endcase
        r.any_free = (head_blk < POOL_SIZE) || (fresh_blk < limit);
        return r;
    endfunction

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [IDX_IN_W-1:0] idx,
                             input logic typed, input reply_t typed_reply,
                             output reply_t predicted);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_block_index <= idx;
        predicted = pool_apply(op, idx);
        pending_replies.push_back(typed ? typed_reply : predicted);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data,
                             input logic lower);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_POOL_BASE:   base_reg = data;
            REG_BLOCK_SIZE:  size_reg = data[BSIZE_W-1:0];
            REG_BLOCK_COUNT: count_reg = data[COUNT_W-1:0];
            default: ;
        endcase
        if (lower) cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("result with no item pending: status %0d index %0d",
                       m_status, m_granted_index);
                mismatches++;
            end else begin
                oldest_reply = pending_replies.pop_front();
                if (m_status !== oldest_reply.status) begin
                    $error("status: expected %0d, got %0d", oldest_reply.status, m_status);
                    mismatches++;
                end
                if (m_granted_index !== oldest_reply.granted_index) begin
                    $error("granted_index: expected %0d, got %0d",
                           oldest_reply.granted_index, m_granted_index);
                    mismatches++;
                end
                if (m_granted_address !== oldest_reply.granted_address) begin
                    $error("granted_address: expected %h, got %h",
                           oldest_reply.granted_address, m_granted_address);
                    mismatches++;
                end
                if (m_any_free !== oldest_reply.any_free) begin
                    $error("any_free: expected %0d, got %0d", oldest_reply.any_free, m_any_free);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        stim_row_t             row;
        reply_t                r;
        logic [OPCODE_W-1:0]   op;
        logic [IDX_IN_W-1:0]   idx;
        logic [31:0]           base_val;
        logic [31:0]           size_val;
        logic [31:0]           count_val;
        int                    roll;
        int                    k;
        int                    limit;

        stim_table = '{
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b1, ST_OK,    10'd0,    40'd0,    1'b1},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b1, ST_OK,    10'd1,    40'd8,    1'b1},
            '{ROW_ITEM, OP_FREE,         32'd1023,       1'b1, ST_OK,    10'd0,    40'd0,    1'b1},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b1, ST_OK,    10'd1023, 40'd8184, 1'b1},
            '{ROW_ITEM, OP_FREE,         32'd0,          1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_NOP,          32'd1023,       1'b1, ST_OK,    10'd0,    40'd0,    1'b1},
            '{ROW_ITEM, OP_CLEAR,        32'd0,          1'b1, ST_OK,    10'd0,    40'd0,    1'b1},
            // two blocks only: run dry, then free past the end
            '{ROW_CFG,  REG_BLOCK_COUNT, 32'd2,          1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b1, ST_OK,    10'd0,    40'd0,    1'b1},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b1, ST_OK,    10'd1,    40'd8,    1'b0},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b1, ST_EMPTY, 10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_FREE,         32'd2,          1'b1, ST_RANGE, 10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_FREE,         32'd1,          1'b1, ST_OK,    10'd0,    40'd0,    1'b1},
            '{ROW_CFG,  REG_POOL_BASE,   32'hFFFF_FFFF,  1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_CFG,  REG_BLOCK_SIZE,  32'hFFFF_FFFF,  1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            // zero count: the block still on the list is handed out anyway
            '{ROW_CFG,  REG_BLOCK_COUNT, 32'd0,          1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_FREE,         32'd0,          1'b1, ST_RANGE, 10'd0,    40'd0,    1'b1},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b1, ST_EMPTY, 10'd0,    40'd0,    1'b0},
            // count above the pool saturates
            '{ROW_CFG,  REG_BLOCK_COUNT, 32'hFFFF_FFFF,  1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_CFG,  REG_UNUSED,      32'hA5A5_A5A5,  1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_FREE,         32'd1023,       1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_CFG,  REG_BLOCK_SIZE,  32'd0,          1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_CLEAR,        32'd0,          1'b0, ST_OK,    10'd0,    40'd0,    1'b0},
            '{ROW_ITEM, OP_ALLOC,        32'd0,          1'b1, ST_OK,    10'd0,
              40'h00_FFFF_FFFF, 1'b1}
        };
        for (k = 0; k < POOL_BLOCKS_DEF; k++) link_mem[k] = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = stim_table[i];
            if (row.kind == ROW_CFG) begin
                if (i == 0 || stim_table[i-1].kind != ROW_CFG) wait_idle();
                write_reg(row.code, row.data,
                          (i == DIR_ROWS - 1) || (stim_table[i+1].kind != ROW_CFG));
            end else begin
                send_item(row.code, row.data[IDX_IN_W-1:0], row.typed,
                          '{row.e_status, row.e_index, row.e_address, row.e_free}, r);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 5)
                0: begin send_idle_pct = 20; recv_idle_pct = 45; end
                1: begin send_idle_pct = 45; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            // registers only change with nothing in flight
            wait_idle();

            roll = $urandom_range(99);
            if (roll < 15) base_val = 32'd0;
            else if (roll < 30) base_val = 32'hFFFF_FFFF;
            else base_val = $urandom;

            roll = $urandom_range(99);
            if (roll < 50) size_val = $urandom_range(8, 65536);
            else if (roll < 75) size_val = $urandom;
            else begin
                case ($urandom_range(3))
                    0: size_val = 32'd0;
                    1: size_val = 32'd8;
                    2: size_val = 32'd65536;
                    default: size_val = 32'h1FFFF;
                endcase
            end

            // mostly tiny pools so the list runs dry and refills often
            roll = $urandom_range(99);
            if (roll < 60) count_val = $urandom_range(1, 12);
            else if (roll < 75) count_val = $urandom_range(13, 64);
            else if (roll < 85) count_val = 32'd0;
            else count_val = $urandom_range(65, 2047);
            if ($urandom_range(3) == 0) count_val[31:COUNT_W] = (32 - COUNT_W)'($urandom);

            write_reg(REG_POOL_BASE, base_val, 1'b0);
            write_reg(REG_BLOCK_SIZE, size_val, 1'b0);
            write_reg(REG_BLOCK_COUNT, count_val, 1'b1);
            limit = int'((count_reg > POOL_SIZE) ? POOL_SIZE : count_reg);

            for (int n = 0; n < SEG_ITEMS; n++) begin
                roll = $urandom_range(99);
                idx = IDX_IN_W'($urandom);
                if (roll < 47) begin
                    op = OP_ALLOC;
                end else if (roll < 84) begin
                    op = OP_FREE;
                    roll = $urandom_range(99);
                    if (roll < 65 && held_blocks.size() != 0) begin
                        k = $urandom_range(held_blocks.size() - 1);
                        idx = IDX_IN_W'(held_blocks[k]);
                        held_blocks.delete(k);
                    end else if (roll < 85) begin
                        idx = IDX_IN_W'($urandom_range(limit + 2 > 1023 ? 1023 : limit + 2));
                    end
                end else if (roll < 91) begin
                    op = OP_CLEAR;
                end else begin
                    op = OP_NOP;
                end
                send_item(op, idx, 1'b0, '0, r);
                if (op == OP_ALLOC && r.status == ST_OK) held_blocks.push_back(r.granted_index);
                if (op == OP_CLEAR) held_blocks.delete();
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
